// ===== design/ima_adpcm_decoder_assert.svh =====
// Assertion macros for the decoder modules; ima_pred includes them.
`ifndef IMA_ADPCM_DECODER_ASSERT_SVH
`define IMA_ADPCM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ima_pkg.sv =====
// Types, constants and tables of the IMA ADPCM decoder.
`default_nettype none
package ima_pkg;

  localparam int unsigned IdxW      = 7;
  localparam int unsigned StepW     = 15;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned StepDepth = 89;
  localparam logic [IdxW-1:0] IdxMax = 7'd88;

  localparam logic [StepW-1:0] StepTab [StepDepth] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  // Nibble on its way from the sequencer to the predictor stage.
  typedef struct packed {
    logic [3:0] nib;
    logic       restart;  // clear predictor before this nibble
    logic       second;   // high nibble of the byte
    logic       last;     // high nibble of the final byte
  } nib_t;

  // Step index move for one code nibble.
  function automatic logic signed [4:0] idx_adj(input logic [3:0] nib);
    logic signed [4:0] r;
    case (nib[2:0])
      3'd4:    r = 5'sd2;
      3'd5:    r = 5'sd4;
      3'd6:    r = 5'sd6;
      3'd7:    r = 5'sd8;
      default: r = -5'sd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ima_adpcm_decoder.sv =====
// Top level of the mono IMA ADPCM 4-bit decoder.
//
//  channel  dir  tdata               tuser            tlast
//  s_axis   in   [7:0] code_byte     [0] restart      last_byte
//  m_axis   out  [15:0] sample       [0] second_of    block_end
//
// Two output words per input byte, one per cycle unless m_axis stalls:
// one nibble per cycle through the step ROM and the single predictor
// add/saturate loop. A new byte is taken as the high nibble of the held
// one issues; each word passes the nibble stage and the output register.
// Reset clears predictor and step index; the step ROM needs no clearing.
// An output stall holds the nibble stage and the ROM read; the input side
// keeps one byte waiting while the stall lasts.
`default_nettype none
module ima_adpcm_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] code_byte
  input  wire logic        s_axis_tuser,   // [0] restart
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] sample
  output logic             m_axis_tuser,   // [0] second_of_pair
  output logic             m_axis_tlast    // block_end
);

  logic                             issue;
  logic                             pred_ready;
  logic [ima_pkg::IdxW-1:0]         rom_addr;
  logic [ima_pkg::StepW-1:0]        step;
  ima_pkg::nib_t                    nib;
  logic signed [ima_pkg::SampleW-1:0] sample;

  ima_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .code_i       (s_axis_tdata),
    .restart_i    (s_axis_tuser),
    .last_i       (s_axis_tlast),
    .next_ready_i (pred_ready),
    .issue_o      (issue),
    .rom_addr_o   (rom_addr),
    .nib_o        (nib)
  );

  ima_step_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (issue),
    .addr_i (rom_addr),
    .step_o (step)
  );

  ima_pred u_pred (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .nib_i       (nib),
    .step_i      (step),
    .ready_o     (pred_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (sample),
    .second_o    (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = sample;

endmodule
`default_nettype wire

// ===== design/ima_step_rom.sv =====
// Step size ROM with a registered read port.
`default_nettype none
module ima_step_rom (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [ima_pkg::IdxW-1:0]   addr_i,
  output logic      [ima_pkg::StepW-1:0]  step_o
);

  logic [ima_pkg::StepW-1:0] step_q;

  // Read only on issue so the data holds while the stage is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= ima_pkg::StepTab[addr_i];
    end
  end

  assign step_o = step_q;

endmodule
`default_nettype wire

// ===== design/ima_seq.sv =====
// Byte holder, nibble sequencer and step index update.
`default_nettype none
module ima_seq (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                code_i,
  input  wire logic                      restart_i,
  input  wire logic                      last_i,
  input  wire logic                      next_ready_i,
  output logic                           issue_o,
  output logic [ima_pkg::IdxW-1:0]       rom_addr_o,
  output ima_pkg::nib_t                  nib_o
);

  logic                      hold_v_q;
  logic                      phase_q;
  logic [ima_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [7:0]                code_q;
  logic                      restart_q;
  logic                      last_q;

  logic [3:0]                nib;
  logic [ima_pkg::IdxW-1:0]  cur_idx;
  logic signed [7:0]         idx_sum;
  logic                      accept;

  always_comb begin
    nib     = phase_q ? code_q[7:4] : code_q[3:0];
    cur_idx = (!phase_q && restart_q) ? '0 : idx_q;
    idx_sum = $signed({1'b0, cur_idx}) + 8'(ima_pkg::idx_adj(nib));
    if (idx_sum < 0) begin
      idx_d = '0;
    end else if (idx_sum > $signed({1'b0, ima_pkg::IdxMax})) begin
      idx_d = ima_pkg::IdxMax;
    end else begin
      idx_d = idx_sum[ima_pkg::IdxW-1:0];
    end
  end

  assign rom_addr_o = (cur_idx > ima_pkg::IdxMax) ? ima_pkg::IdxMax : cur_idx;
  assign issue_o    = hold_v_q && next_ready_i;
  // A new byte comes in when none is held, or as the high nibble of the held one leaves.
  assign in_ready_o = !hold_v_q || (issue_o && phase_q);
  assign accept     = in_valid_i && in_ready_o;

  assign nib_o.nib     = nib;
  assign nib_o.restart = !phase_q && restart_q;
  assign nib_o.second  = phase_q;
  assign nib_o.last    = phase_q && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      phase_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (accept) begin
        hold_v_q <= 1'b1;
        phase_q  <= 1'b0;
      end else if (issue_o) begin
        if (phase_q) begin
          hold_v_q <= 1'b0;
        end
        phase_q <= ~phase_q;
      end
      if (issue_o) begin
        idx_q <= idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q    <= code_i;
      restart_q <= restart_i;
      last_q    <= last_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/ima_pred.sv =====
// Difference, predictor update with saturation, and output register.
`default_nettype none
`include "ima_adpcm_decoder_assert.svh"
module ima_pred (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              issue_i,
  input  wire ima_pkg::nib_t                     nib_i,
  input  wire logic [ima_pkg::StepW-1:0]         step_i,
  output logic                                   ready_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [ima_pkg::SampleW-1:0]     sample_o,
  output logic                                   second_o,
  output logic                                   last_o
);

  logic                                 st_v_q;
  ima_pkg::nib_t                        st_q;
  logic signed [ima_pkg::SampleW-1:0]   pred_q, pred_d;
  logic                                 out_v_q;
  logic signed [ima_pkg::SampleW-1:0]   sample_q;
  logic                                 second_q;
  logic                                 last_q;

  logic                                 out_free;
  logic                                 move;
  logic [3:0]                           mult;
  logic [ima_pkg::StepW+3:0]            prod;
  logic [ima_pkg::SampleW-1:0]          diff;
  logic signed [ima_pkg::SampleW-1:0]   base;
  logic signed [ima_pkg::SampleW+1:0]   sum;

  assign out_free = !out_v_q || out_ready_i;
  assign ready_o  = !st_v_q || out_free;
  assign move     = st_v_q && out_free;

  always_comb begin
    mult = {st_q.nib[2:0], 1'b1};
    prod = (ima_pkg::StepW+4)'(mult) * (ima_pkg::StepW+4)'(step_i);
    diff = prod[ima_pkg::StepW+3:3];
    base = st_q.restart ? '0 : pred_q;
    if (st_q.nib[3]) begin
      sum = 18'(base) - $signed({2'b00, diff});
    end else begin
      sum = 18'(base) + $signed({2'b00, diff});
    end
    if (sum < -18'sd32768) begin
      pred_d = 16'sh8000;
    end else if (sum > 18'sd32767) begin
      pred_d = 16'sh7fff;
    end else begin
      pred_d = sum[ima_pkg::SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pred_q  <= '0;
    end else begin
      if (ready_o) begin
        st_v_q <= issue_i;
      end
      if (out_free) begin
        out_v_q <= st_v_q;
      end
      if (move) begin
        pred_q <= pred_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      st_q <= nib_i;
    end
    if (move) begin
      sample_q <= pred_d;
      second_q <= st_q.second;
      last_q   <= st_q.last;
    end
  end

  assign out_valid_o = out_v_q;
  assign sample_o    = sample_q;
  assign second_o    = second_q;
  assign last_o      = last_q;

  `IMA_ASSERT_NOW(a_end_on_high, out_v_q && last_q, second_q, "block end on low nibble")
  `IMA_ASSERT_NEXT(a_pred_hold, !move, $stable(pred_q), "predictor changed without a move")
  `IMA_ASSERT_NEXT(a_stage_hold, st_v_q && !out_free, st_v_q && $stable(st_q),
                   "stalled nibble lost")
  `IMA_ASSERT_NEXT(a_out_tracks_pred, move, out_v_q && sample_q == pred_q,
                   "output word differs from predictor")

endmodule
`default_nettype wire

// ===== bench/ima_adpcm_checker.sv =====
// Checker for the IMA ADPCM decoder: predicts PCM words from accepted code bytes and compares.
`timescale 1ns / 1ps
module ima_adpcm_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,   // [7:0] code_byte
  input  wire logic        s_tuser_i,   // [0] restart
  input  wire logic        s_tlast_i,   // last_byte
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [15:0] m_tdata_i,   // [15:0] sample
  input  wire logic        m_tuser_i,   // [0] second_of_pair
  input  wire logic        m_tlast_i,   // block_end
  output int               err_cnt_o,
  output int               pending_o
);

  localparam int IdxTop = 88;

  localparam logic [14:0] StepLut [IdxTop+1] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  typedef struct packed {
    logic [15:0] sample;
    logic        second;
    logic        block_end;
  } pcm_word_t;

  pcm_word_t          pcm_q[$];
  logic signed [15:0] pcm_pred;
  logic [6:0]         step_idx;
  int                 err_cnt = 0;

  assign err_cnt_o = err_cnt;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (err_cnt < 40)
      $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // One nibble through the step table, index adapt and saturating add.
  task automatic decode_nibble(input logic [3:0] nib, output logic [15:0] smp);
    int step;
    int nidx;
    int diff;
    int acc;
    step = int'(StepLut[(int'(step_idx) > IdxTop) ? IdxTop : int'(step_idx)]);
    nidx = (int'(step_idx) > IdxTop) ? IdxTop : int'(step_idx);
    nidx = nib[2] ? nidx + 2 * (int'(nib[2:0]) - 3) : nidx - 1;
    if (nidx < 0) nidx = 0;
    if (nidx > IdxTop) nidx = IdxTop;
    step_idx = nidx[6:0];
    diff = ((2 * int'(nib[2:0]) + 1) * step) >>> 3;
    if (nib[3]) diff = -diff;
    acc = int'(pcm_pred) + diff;
    if (acc < -32768) acc = -32768;
    if (acc > 32767) acc = 32767;
    pcm_pred = acc[15:0];
    smp = acc[15:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pcm_word_t w;
    pcm_word_t want;
    if (!rst_ni) begin
      pcm_pred = '0;
      step_idx = '0;
      pcm_q.delete();
      pending_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i) begin
          pcm_pred = '0;
          step_idx = '0;
        end
        decode_nibble(s_tdata_i[3:0], w.sample);
        w.second    = 1'b0;
        w.block_end = 1'b0;
        pcm_q.push_back(w);
        decode_nibble(s_tdata_i[7:4], w.sample);
        w.second    = 1'b1;
        w.block_end = s_tlast_i;
        pcm_q.push_back(w);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pcm_q.size() == 0) begin
          report("unexpected word", m_tdata_i, 16'h0000);
        end else begin
          want = pcm_q.pop_front();
          if (m_tdata_i !== want.sample)
            report("sample", m_tdata_i, want.sample);
          if (m_tuser_i !== want.second)
            report("second_of_pair", {15'd0, m_tuser_i}, {15'd0, want.second});
          if (m_tlast_i !== want.block_end)
            report("block_end", {15'd0, m_tlast_i}, {15'd0, want.block_end});
        end
      end
      pending_o = pcm_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the IMA ADPCM decoder: clock, reset, code byte stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int NumRandBytes = 1100;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          err_cnt;
  int          pending;

  int          burst_left = 0;
  int          sent_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ima_adpcm_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  ima_adpcm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  // Receiver stalls in one of four modes, redrawn at random when the current one runs out.
  stall_mode_e stall_mode = StallNone;
  int          mode_left = 0;
  int          phase = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 256);
    end else begin
      mode_left--;
    end
    phase = (phase + 1) % 16;
    case (stall_mode)
      StallNone:     m_tready <= 1'b1;
      StallLight:    m_tready <= ($urandom_range(0, 3) != 0);
      StallHeavy:    m_tready <= ($urandom_range(0, 3) == 0);
      StallPeriodic: m_tready <= (phase < 4);
      default:       m_tready <= 1'b1;
    endcase
  end

  // Offers one code byte and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] code, input logic rst_flag, input logic last_flag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= code;
    s_tuser  <= rst_flag;
    s_tlast  <= last_flag;
    do @(posedge clk_i); while (!s_tready);
    sent_cnt++;
  endtask

  // Nibble biased toward one corner of the code space.
  function automatic logic [3:0] biased_nibble(input int bias);
    logic [3:0] n;
    n = 4'($urandom_range(0, 15));
    case (bias)
      1: n = {1'b0, 1'b1, n[1:0]};   // large positive steps
      2: n = {1'b1, 1'b1, n[1:0]};   // large negative steps
      3: n = {n[3], 1'b0, n[1:0]};   // shrink the step index
      default: ;
    endcase
    return n;
  endfunction

  initial begin
    int blk_len;
    int bias;
    logic [7:0] code;
    logic rflag;
    logic lflag;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // index clamp at 0, climb to top index and positive rail, then negative rail
    send_byte(8'h00, 1'b1, 1'b0);
    repeat (8) send_byte(8'h77, 1'b0, 1'b0);
    repeat (3) send_byte(8'hFF, 1'b0, 1'b0);
    // every nibble value once
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h54, 1'b0, 1'b0);
    send_byte(8'h76, 1'b0, 1'b0);
    send_byte(8'h98, 1'b0, 1'b0);
    send_byte(8'hBA, 1'b0, 1'b0);
    send_byte(8'hDC, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1);
    // restart together with last byte, then state kept across the block end
    send_byte(8'h88, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b1);

    sent_cnt = 0;
    while (sent_cnt < NumRandBytes) begin
      blk_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      bias    = $urandom_range(0, 3);
      for (int i = 0; i < blk_len; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          code = 8'($urandom_range(0, 255));
        end else begin
          code = {biased_nibble(bias), biased_nibble(bias)};
        end
        rflag = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 60) == 0);
        lflag = (i == blk_len - 1) ? 1'b1 : ($urandom_range(0, 80) == 0);
        send_byte(code, rflag, lflag);
      end
    end

    s_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
